@@ src/msixt_pkg.sv @@
`default_nettype none

package msixt_pkg;

  localparam int unsigned ENTRY_BYTES = 16;
  localparam int unsigned CTRL_BYTE   = 12;
  localparam int unsigned MAX_SIZE    = 8;
  localparam int unsigned PBA_BITS    = 64;

  typedef enum logic [2:0] {
    MODE_TRIGGER = 3'd0,
    MODE_TBL_RD  = 3'd1,
    MODE_TBL_WR  = 3'd2,
    MODE_PBA_RD  = 3'd3,
    MODE_PBA_WR  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    CFG_ENABLE  = 2'd0,
    CFG_FMASK   = 2'd1,
    CFG_ENTRIES = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } state_e;

  typedef struct packed {
    logic clear;
    logic issue;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

`default_nettype wire

@@ src/msixt_ctrl.sv @@
`default_nettype none

module msixt_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  input  msixt_pkg::dp_status_t status_i,
  output msixt_pkg::ctrl_cmd_t  cmd_o
);

  msixt_pkg::state_e state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      msixt_pkg::ST_CLEAR: begin
        if (status_i.clear_last) begin
          state_d = msixt_pkg::ST_IDLE;
        end
      end
      msixt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = msixt_pkg::ST_EXEC;
        end
      end
      msixt_pkg::ST_EXEC: begin
        if (out_free) begin
          state_d = msixt_pkg::ST_IDLE;
        end
      end
      default: state_d = msixt_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o.clear = 1'b0;
    cmd_o.issue = 1'b0;
    cmd_o.exec  = 1'b0;
    in_stall_o  = 1'b1;
    case (state_q)
      msixt_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      msixt_pkg::ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.issue = in_valid_i;
      end
      msixt_pkg::ST_EXEC: begin
        cmd_o.exec = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msixt_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_to_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == msixt_pkg::ST_EXEC))
    else $error("accepted item did not enter execution");

  a_exec_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_o)
    else $error("executed item produced no result");

  a_exec_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == msixt_pkg::ST_EXEC && !out_valid_q) |=> (state_q != msixt_pkg::ST_EXEC))
    else $error("execution stalled with a free output register");

  a_no_issue_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == msixt_pkg::ST_CLEAR) |=> !$past(cmd_o.issue))
    else $error("item issued during clearing pass");

endmodule

`default_nettype wire

@@ src/msixt_dp.sv @@
`default_nettype none

module msixt_dp #(
  parameter int VECTORS = 64
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  msixt_pkg::ctrl_cmd_t  cmd_i,
  output msixt_pkg::dp_status_t status_o,
  input  wire                   cfg_we_i,
  input  wire  [1:0]            cfg_index_i,
  input  wire  [6:0]            cfg_data_i,
  input  wire  [2:0]            mode_i,
  input  wire  [15:0]           offset_i,
  input  wire  [63:0]           write_value_i,
  input  wire  [3:0]            access_size_i,
  input  wire  [15:0]           vector_i,
  output logic [63:0]           read_data_o,
  output logic                  res_status_o,
  output logic                  irq_fired_o,
  output logic [5:0]            irq_vector_o,
  output logic [31:0]           irq_total_o
);

  localparam int AW        = (VECTORS > 1) ? $clog2(VECTORS) : 1;
  localparam int PBA_WORDS = (VECTORS + 63) / 64;
  localparam int PW        = (PBA_WORDS > 1) ? $clog2(PBA_WORDS) : 1;
  localparam int EB        = msixt_pkg::ENTRY_BYTES;

  logic [8*EB-1:0]            tbl_mem [VECTORS];
  logic                       mask_mem [VECTORS];
  logic [31:0]                cnt_mem [VECTORS];
  logic [msixt_pkg::PBA_BITS-1:0] pba_mem [PBA_WORDS];

  logic [8*EB-1:0]            tbl_rd_q;
  logic                       mask_rd_q;
  logic [31:0]                cnt_rd_q;
  logic [msixt_pkg::PBA_BITS-1:0] pba_rd_q;

  logic                       enable_q, fmask_q;
  logic [6:0]                 entries_q;

  logic [2:0]                 mode_q;
  logic [15:0]                offset_q;
  logic [63:0]                write_value_q;
  logic [3:0]                 access_size_q;
  logic [15:0]                vector_q;

  logic [AW-1:0]              clr_cnt_q, clr_cnt_d;

  logic [PW-1:0]              pba_raddr;

  logic [3:0]                 eoff;
  logic [11:0]                idx;
  logic [12:0]                pword;
  logic                       idx_ok, size_ok, fits, ctrl_wr, vec_ok, fire, pba_ok;
  logic [7:0]                 lane_en;
  logic [8*EB-1:0]            rd_shift, wr_shift, tbl_merged;
  logic [EB-1:0]              be;
  logic [63:0]                tbl_rdata;

  logic                       tbl_we, mask_we, cnt_we, pba_we;
  logic [AW-1:0]              tbl_waddr, vec_addr, cnt_waddr;
  logic [8*EB-1:0]            tbl_wdata;
  logic                       mask_wdata;
  logic [31:0]                cnt_wdata;
  logic [PW-1:0]              pba_waddr;
  logic [msixt_pkg::PBA_BITS-1:0] pba_wdata;

  logic [63:0]                rdata_d, rdata_q;
  logic                       stat_d, stat_q;
  logic                       fired_d, fired_q;
  logic [5:0]                 ivec_d, ivec_q;
  logic [31:0]                total_d, total_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      fmask_q   <= 1'b0;
      entries_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        msixt_pkg::CFG_ENABLE:  enable_q  <= cfg_data_i[0];
        msixt_pkg::CFG_FMASK:   fmask_q   <= cfg_data_i[0];
        msixt_pkg::CFG_ENTRIES: entries_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clearing pass
  assign status_o.clear_last = cmd_i.clear && (clr_cnt_q == AW'(VECTORS - 1));
  assign clr_cnt_d = status_o.clear_last ? '0 : clr_cnt_q + AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // item capture and memory reads
  assign pba_raddr = (mode_i == msixt_pkg::MODE_PBA_RD) ? offset_i[3 +: PW] : vector_i[6 +: PW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      mode_q        <= mode_i;
      offset_q      <= offset_i;
      write_value_q <= write_value_i;
      access_size_q <= access_size_i;
      vector_q      <= vector_i;
      tbl_rd_q      <= tbl_mem[offset_i[4 +: AW]];
      mask_rd_q     <= mask_mem[vector_i[AW-1:0]];
      cnt_rd_q      <= cnt_mem[vector_i[AW-1:0]];
      pba_rd_q      <= pba_mem[pba_raddr];
    end
  end

  // execution
  assign eoff     = offset_q[3:0];
  assign idx      = offset_q[15:4];
  assign pword    = offset_q[15:3];
  assign vec_addr = vector_q[AW-1:0];

  assign idx_ok  = (32'(idx) < 32'(entries_q)) && (32'(idx) < 32'(VECTORS));
  assign size_ok = access_size_q <= 4'(msixt_pkg::MAX_SIZE);
  assign fits    = (5'(eoff) + 5'(access_size_q)) <= 5'(EB);
  assign ctrl_wr = (eoff == 4'(msixt_pkg::CTRL_BYTE)) && (access_size_q >= 4'd4);
  assign vec_ok  = 32'(vector_q) < 32'(VECTORS);
  assign pba_ok  = ((32'(pword) << 6) < 32'(entries_q)) &&
                   ((32'(pword) << 6) < 32'(VECTORS));
  assign fire    = (mode_q == msixt_pkg::MODE_TRIGGER) && vec_ok && enable_q &&
                   !fmask_q && !mask_rd_q;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      lane_en[i] = 4'(i) < access_size_q;
    end
  end

  assign rd_shift = tbl_rd_q >> {eoff, 3'b000};
  assign wr_shift = {{(8*EB-64){1'b0}}, write_value_q} << {eoff, 3'b000};
  assign be       = EB'({{(EB-8){1'b0}}, lane_en} << eoff);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      tbl_rdata[8*i +: 8] = lane_en[i] ? rd_shift[8*i +: 8] : 8'd0;
    end
    for (int b = 0; b < EB; b++) begin
      tbl_merged[8*b +: 8] = be[b] ? wr_shift[8*b +: 8] : tbl_rd_q[8*b +: 8];
    end
  end

  always_comb begin
    rdata_d = '0;
    stat_d  = 1'b0;
    fired_d = 1'b0;
    ivec_d  = '0;
    total_d = '0;
    case (mode_q)
      msixt_pkg::MODE_TRIGGER: begin
        stat_d  = !vec_ok;
        fired_d = fire;
        ivec_d  = fire ? vector_q[5:0] : 6'd0;
        total_d = fire ? cnt_rd_q + 32'd1 : 32'd0;
      end
      msixt_pkg::MODE_TBL_RD: begin
        if (idx_ok && size_ok && fits) begin
          rdata_d = tbl_rdata;
        end
      end
      msixt_pkg::MODE_PBA_RD: begin
        if (pba_ok) begin
          rdata_d = pba_rd_q;
        end
      end
      default: rdata_d = '0;
    endcase
  end

  // memory writes
  assign tbl_we     = cmd_i.clear || (cmd_i.exec && (mode_q == msixt_pkg::MODE_TBL_WR) &&
                      idx_ok && size_ok && fits);
  assign tbl_waddr  = cmd_i.clear ? clr_cnt_q : idx[AW-1:0];
  assign tbl_wdata  = cmd_i.clear ? '0 : tbl_merged;
  assign mask_we    = cmd_i.clear || (cmd_i.exec && (mode_q == msixt_pkg::MODE_TBL_WR) &&
                      idx_ok && size_ok && ctrl_wr);
  assign mask_wdata = cmd_i.clear ? 1'b0 : write_value_q[0];
  assign cnt_we     = cmd_i.clear || (cmd_i.exec && fire);
  assign cnt_waddr  = cmd_i.clear ? clr_cnt_q : vec_addr;
  assign cnt_wdata  = cmd_i.clear ? 32'd0 : cnt_rd_q + 32'd1;
  assign pba_we     = (cmd_i.clear && (32'(clr_cnt_q) < 32'(PBA_WORDS))) ||
                      (cmd_i.exec && fire);
  assign pba_waddr  = cmd_i.clear ? clr_cnt_q[PW-1:0] : vector_q[6 +: PW];
  assign pba_wdata  = cmd_i.clear ? '0 : (pba_rd_q | (64'd1 << vector_q[5:0]));

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (mask_we) begin
      mask_mem[tbl_waddr] <= mask_wdata;
    end
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (pba_we) begin
      pba_mem[pba_waddr] <= pba_wdata;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rdata_q <= rdata_d;
      stat_q  <= stat_d;
      fired_q <= fired_d;
      ivec_q  <= ivec_d;
      total_q <= total_d;
    end
  end

  assign read_data_o  = rdata_q;
  assign res_status_o = stat_q;
  assign irq_fired_o  = fired_q;
  assign irq_vector_o = ivec_q;
  assign irq_total_o  = total_q;

endmodule

`default_nettype wire

@@ src/msix_table_and_pending_array.sv @@
// results: an accepted item is captured with its memory reads, then enters
// the output register once any earlier result stalled there has been taken
// items: none is taken while one executes, due to the registered read of the
// table, mask, count and pending memories ahead of their read-modify-write
// reset: after rst_ni rises a clearing pass over all VECTORS entries zeroes
// the memories; input stays stalled meanwhile, configuration writes are taken
`default_nettype none

module msix_table_and_pending_array #(
  parameter int VECTORS = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [6:0]  cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [2:0]  mode_i,
  input  wire  [15:0] offset_i,
  input  wire  [63:0] write_value_i,
  input  wire  [3:0]  access_size_i,
  input  wire  [15:0] vector_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [63:0] read_data_o,
  output logic        status_o,
  output logic        irq_fired_o,
  output logic [5:0]  irq_vector_o,
  output logic [31:0] irq_total_o
);

  msixt_pkg::ctrl_cmd_t  cmd;
  msixt_pkg::dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  msixt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  msixt_dp #(
    .VECTORS (VECTORS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (dp_status),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mode_i        (mode_i),
    .offset_i      (offset_i),
    .write_value_i (write_value_i),
    .access_size_i (access_size_i),
    .vector_i      (vector_i),
    .read_data_o   (read_data_o),
    .res_status_o  (status_o),
    .irq_fired_o   (irq_fired_o),
    .irq_vector_o  (irq_vector_o),
    .irq_total_o   (irq_total_o)
  );

endmodule

`default_nettype wire
